@@ src/htlf_pkg.sv @@
// htlf_pkg: shared types and constants of the handle table
// used by every module of the handle table; depends on nothing
package htlf_pkg;

    // port field widths
    localparam int OPCODE_W = 3;
    localparam int HANDLE_W = 8;
    localparam int RES_IN_W = 16;
    localparam int OFFSET_W = 48;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int USED_W   = 7;

    // slots examined per scan cycle
    localparam int GROUP_W  = 8;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INHERIT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_GET     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLOSE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_UP,
        S_SCAN_DOWN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic up_step;
        logic down_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic op_alloc;
        logic close_ok;
        logic up_done;
        logic down_done;
        logic out_free;
    } sts_t;

endpackage

@@ src/handle_table_lowest_free_top.sv @@
// handle_table_lowest_free_top: handle table with lowest-free-slot allocation
// depends on htlf_pkg, htlf_ctrl and htlf_datapath
//
// One request is taken at a time; in_ready is high only while no request is in work,
// and a finished result waits in the output register without blocking the next request.
// Inherit, get, clear and bad requests go from the accepting edge through the execute and
// publish states to the output register, and only then is a new request taken. Alloc
// adds an upward scan for the lowest free slot, one group of 8 slots at a time; a good
// close adds a downward scan, group by group, to find the new used count. A result still
// waiting on the output holds the next request in its publish state. The scan over the
// valid bits examines 8 slots per cycle. No clearing pass is needed after reset: slot
// valid bits are cleared at once.
module handle_table_lowest_free_top #(
    parameter int TABLE_DEPTH      = 64,
    parameter int RESOURCE_ID_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [htlf_pkg::OPCODE_W-1:0]     opcode,
    input  logic [htlf_pkg::HANDLE_W-1:0]     handle_index,
    input  logic [htlf_pkg::RES_IN_W-1:0]     resource_id,
    input  logic [htlf_pkg::OFFSET_W-1:0]     start_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [htlf_pkg::STATUS_W-1:0]     status,
    output logic [htlf_pkg::SLOT_W-1:0]       slot_index,
    output logic [htlf_pkg::RES_IN_W-1:0]     found_resource,
    output logic [htlf_pkg::OFFSET_W-1:0]     found_offset,
    output logic [htlf_pkg::USED_W-1:0]       used_count
);

    localparam int RES_W = (RESOURCE_ID_BITS < htlf_pkg::RES_IN_W)
                         ? RESOURCE_ID_BITS : htlf_pkg::RES_IN_W;

    htlf_pkg::cmd_t cmd;
    htlf_pkg::sts_t sts;

    htlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    htlf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RES_W       (RES_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .handle_index   (handle_index),
        .resource_id    (resource_id),
        .start_offset   (start_offset),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .slot_index     (slot_index),
        .found_resource (found_resource),
        .found_offset   (found_offset),
        .used_count     (used_count)
    );

endmodule

@@ src/htlf_ctrl.sv @@
// htlf_ctrl: request sequencing state machine of the handle table
// depends on htlf_pkg; drives the datapath through cmd_t, watches sts_t
module htlf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  htlf_pkg::sts_t  sts,
    output htlf_pkg::cmd_t  cmd
);

    htlf_pkg::state_t state_reg;
    htlf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htlf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htlf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = htlf_pkg::S_EXEC;
                end
            end
            htlf_pkg::S_EXEC:
            begin
                if (sts.op_alloc)
                begin
                    state_next = htlf_pkg::S_SCAN_UP;
                end
                else if (sts.close_ok)
                begin
                    state_next = htlf_pkg::S_SCAN_DOWN;
                end
                else
                begin
                    state_next = htlf_pkg::S_DONE;
                end
            end
            htlf_pkg::S_SCAN_UP:
            begin
                if (sts.up_done)
                begin
                    state_next = htlf_pkg::S_DONE;
                end
            end
            htlf_pkg::S_SCAN_DOWN:
            begin
                if (sts.down_done)
                begin
                    state_next = htlf_pkg::S_DONE;
                end
            end
            htlf_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = htlf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = htlf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            htlf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            htlf_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            htlf_pkg::S_SCAN_UP:
            begin
                cmd.up_step = 1'b1;
            end
            htlf_pkg::S_SCAN_DOWN:
            begin
                cmd.down_step = 1'b1;
            end
            htlf_pkg::S_DONE:
            begin
                cmd.publish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/htlf_datapath.sv @@
// htlf_datapath: slot storage, valid bits, span register, group scanner, output register
// depends on htlf_pkg; sequenced by htlf_ctrl
module htlf_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int RES_W       = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  htlf_pkg::cmd_t                    cmd,
    output htlf_pkg::sts_t                    sts,
    input  logic [htlf_pkg::OPCODE_W-1:0]     opcode,
    input  logic [htlf_pkg::HANDLE_W-1:0]     handle_index,
    input  logic [htlf_pkg::RES_IN_W-1:0]     resource_id,
    input  logic [htlf_pkg::OFFSET_W-1:0]     start_offset,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [htlf_pkg::STATUS_W-1:0]     status,
    output logic [htlf_pkg::SLOT_W-1:0]       slot_index,
    output logic [htlf_pkg::RES_IN_W-1:0]     found_resource,
    output logic [htlf_pkg::OFFSET_W-1:0]     found_offset,
    output logic [htlf_pkg::USED_W-1:0]       used_count
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SPAN_W  = $clog2(TABLE_DEPTH + 1);
    localparam int NGROUPS = (TABLE_DEPTH + htlf_pkg::GROUP_W - 1) / htlf_pkg::GROUP_W;
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int POS_W   = $clog2(htlf_pkg::GROUP_W);
    localparam int PIDX_W  = GRP_W + POS_W;
    localparam int PAD     = NGROUPS * htlf_pkg::GROUP_W;

    // request registers
    logic [htlf_pkg::OPCODE_W-1:0] op_reg;
    logic [htlf_pkg::HANDLE_W-1:0] idx_reg;
    logic [RES_W-1:0]              res_reg;
    logic [htlf_pkg::OFFSET_W-1:0] off_reg;

    // table state
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [SPAN_W-1:0]      span_reg;
    logic [SPAN_W-1:0]      span_next;
    logic [GRP_W-1:0]       grp_reg;
    logic [GRP_W-1:0]       grp_next;

    logic [RES_W-1:0]              res_mem [TABLE_DEPTH];
    logic [htlf_pkg::OFFSET_W-1:0] off_mem [TABLE_DEPTH];
    logic [RES_W-1:0]              rd_res_reg;
    logic [htlf_pkg::OFFSET_W-1:0] rd_off_reg;

    // result of the current request
    logic [htlf_pkg::STATUS_W-1:0] st_reg;
    logic [htlf_pkg::STATUS_W-1:0] st_next;
    logic [htlf_pkg::SLOT_W-1:0]   slot_reg;
    logic [htlf_pkg::SLOT_W-1:0]   slot_next;
    logic                          get_ok_reg;
    logic                          get_ok_next;

    // output register
    logic                          out_valid_reg;
    logic [htlf_pkg::STATUS_W-1:0] out_st_reg;
    logic [htlf_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [htlf_pkg::RES_IN_W-1:0] out_res_reg;
    logic [htlf_pkg::OFFSET_W-1:0] out_off_reg;
    logic [htlf_pkg::USED_W-1:0]   out_used_reg;

    logic [IDX_W-1:0]              a_req;
    logic                          in_range;
    logic                          slot_vld;
    logic                          inherit_ok;
    logic [PAD-1:0]                valid_pad;
    logic [PIDX_W-1:0]             top_p;
    logic [GRP_W-1:0]              dn_grp;
    logic [POS_W-1:0]              dn_lim;
    logic [GRP_W-1:0]              grp_sel;
    logic [htlf_pkg::GROUP_W-1:0]  grp_bits;
    logic [htlf_pkg::GROUP_W-1:0]  up_free;
    logic [htlf_pkg::GROUP_W-1:0]  dn_bits;
    logic                          up_hit;
    logic                          dn_hit;
    logic [POS_W-1:0]              up_pos;
    logic [POS_W-1:0]              dn_pos;
    logic [PIDX_W-1:0]             up_slot;
    logic [IDX_W-1:0]              up_addr;
    logic [SPAN_W-1:0]             up_span;
    logic [SPAN_W-1:0]             dn_span;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [htlf_pkg::OFFSET_W-1:0] mem_woff;

    assign a_req      = IDX_W'(idx_reg);
    assign in_range   = (32'(idx_reg) < TABLE_DEPTH);
    assign slot_vld   = in_range && valid_reg[a_req];
    assign inherit_ok = in_range && !valid_reg[a_req];

    // pad slots past the depth read as occupied
    for (genvar g = 0; g < PAD; g++)
    begin : g_pad
        if (g < TABLE_DEPTH)
        begin : g_real
            assign valid_pad[g] = valid_reg[g];
        end
        else
        begin : g_fill
            assign valid_pad[g] = 1'b1;
        end
    end

    // group selection for the upward and downward scans
    assign top_p    = PIDX_W'(span_reg) - PIDX_W'(1);
    assign dn_grp   = top_p[PIDX_W-1:POS_W];
    assign dn_lim   = top_p[POS_W-1:0];
    assign grp_sel  = cmd.down_step ? dn_grp : grp_reg;
    assign grp_bits = valid_pad[{grp_sel, POS_W'(0)} +: htlf_pkg::GROUP_W];
    assign up_free  = ~grp_bits;
    assign up_hit   = |up_free;
    assign dn_hit   = |dn_bits;

    always_comb
    begin
        up_pos = '0;
        for (int i = htlf_pkg::GROUP_W - 1; i >= 0; i--)
        begin
            if (up_free[i])
            begin
                up_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        dn_pos = '0;
        for (int i = 0; i < htlf_pkg::GROUP_W; i++)
        begin
            dn_bits[i] = grp_bits[i] && (POS_W'(i) <= dn_lim);
            if (dn_bits[i])
            begin
                dn_pos = POS_W'(i);
            end
        end
    end

    assign up_slot = {grp_reg, up_pos};
    assign up_addr = IDX_W'(up_slot);
    assign up_span = SPAN_W'(up_slot) + SPAN_W'(1);
    assign dn_span = dn_hit ? (SPAN_W'({dn_grp, dn_pos}) + SPAN_W'(1))
                            : SPAN_W'({dn_grp, POS_W'(0)});

    assign sts.op_alloc  = (op_reg == htlf_pkg::OP_ALLOC);
    assign sts.close_ok  = (op_reg == htlf_pkg::OP_CLOSE) && slot_vld;
    assign sts.up_done   = up_hit || (32'(grp_reg) == NGROUPS - 1);
    assign sts.down_done = (span_reg == '0) || dn_hit || (dn_grp == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // memory write port
    assign mem_we    = (cmd.exec && (op_reg == htlf_pkg::OP_INHERIT) && inherit_ok)
                    || (cmd.up_step && up_hit);
    assign mem_waddr = cmd.up_step ? up_addr : a_req;
    assign mem_woff  = cmd.up_step ? '0 : off_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        span_next   = span_reg;
        grp_next    = grp_reg;
        st_next     = st_reg;
        slot_next   = slot_reg;
        get_ok_next = get_ok_reg;
        if (cmd.exec)
        begin
            grp_next    = '0;
            get_ok_next = 1'b0;
            slot_next   = htlf_pkg::SLOT_W'(idx_reg);
            st_next     = htlf_pkg::ST_OK;
            case (op_reg)
                htlf_pkg::OP_ALLOC:
                begin
                    st_next   = htlf_pkg::ST_FULL;
                    slot_next = '0;
                end
                htlf_pkg::OP_INHERIT:
                begin
                    if (!in_range)
                    begin
                        st_next = htlf_pkg::ST_FULL;
                    end
                    else if (valid_reg[a_req])
                    begin
                        st_next = htlf_pkg::ST_BUSY;
                    end
                    else
                    begin
                        valid_next[a_req] = 1'b1;
                        if (SPAN_W'(a_req) + SPAN_W'(1) > span_reg)
                        begin
                            span_next = SPAN_W'(a_req) + SPAN_W'(1);
                        end
                    end
                end
                htlf_pkg::OP_GET:
                begin
                    if (slot_vld)
                    begin
                        get_ok_next = 1'b1;
                    end
                    else
                    begin
                        st_next = htlf_pkg::ST_BAD;
                    end
                end
                htlf_pkg::OP_CLOSE:
                begin
                    if (slot_vld)
                    begin
                        valid_next[a_req] = 1'b0;
                    end
                    else
                    begin
                        st_next = htlf_pkg::ST_BAD;
                    end
                end
                htlf_pkg::OP_CLEAR:
                begin
                    valid_next = '0;
                    span_next  = '0;
                    slot_next  = '0;
                end
                default:
                begin
                    st_next   = htlf_pkg::ST_BAD;
                    slot_next = '0;
                end
            endcase
        end
        if (cmd.up_step)
        begin
            if (up_hit)
            begin
                valid_next[up_addr] = 1'b1;
                st_next             = htlf_pkg::ST_OK;
                slot_next           = htlf_pkg::SLOT_W'(up_slot);
                if (up_span > span_reg)
                begin
                    span_next = up_span;
                end
            end
            else if (!sts.up_done)
            begin
                grp_next = grp_reg + GRP_W'(1);
            end
        end
        if (cmd.down_step && (span_reg != '0))
        begin
            span_next = dn_span;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            span_reg      <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            span_reg  <= span_next;
            grp_reg   <= grp_next;
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        slot_reg   <= slot_next;
        get_ok_reg <= get_ok_next;
        if (cmd.load)
        begin
            op_reg  <= opcode;
            idx_reg <= handle_index;
            res_reg <= RES_W'(resource_id);
            off_reg <= start_offset;
        end
        if (cmd.publish)
        begin
            out_st_reg   <= st_reg;
            out_slot_reg <= slot_reg;
            out_res_reg  <= get_ok_reg ? htlf_pkg::RES_IN_W'(rd_res_reg) : '0;
            out_off_reg  <= get_ok_reg ? rd_off_reg : '0;
            out_used_reg <= htlf_pkg::USED_W'(span_reg);
        end
    end

    // slot memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            res_mem[mem_waddr] <= res_reg;
            off_mem[mem_waddr] <= mem_woff;
        end
        rd_res_reg <= res_mem[a_req];
        rd_off_reg <= off_mem[a_req];
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign slot_index     = out_slot_reg;
    assign found_resource = out_res_reg;
    assign found_offset   = out_off_reg;
    assign used_count     = out_used_reg;

endmodule

@@ src/htlf_checker.sv @@
// htlf_checker: port-level checks of the handle table, bound to the top level
// depends on htlf_pkg and handle_table_lowest_free_top
module htlf_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [htlf_pkg::STATUS_W-1:0]     status,
    input logic [htlf_pkg::SLOT_W-1:0]       slot_index,
    input logic [htlf_pkg::RES_IN_W-1:0]     found_resource,
    input logic [htlf_pkg::OFFSET_W-1:0]     found_offset,
    input logic [htlf_pkg::USED_W-1:0]       used_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
            && $stable(found_resource) && $stable(found_offset) && $stable(used_count))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

    // slot contents only come back on a good request
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != htlf_pkg::ST_OK) |-> (found_resource == '0)
            && (found_offset == '0))
        else $error("slot contents on a failed request");

    // used count never passes the depth
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(used_count) <= TABLE_DEPTH))
        else $error("used count beyond table depth");

endmodule

bind handle_table_lowest_free_top htlf_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_htlf_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench of handle_table_lowest_free_top
// holds its own handle table predictor and checks every reply; depends on htlf_pkg and the rtl
module tb_top;

    localparam int DEPTH      = 64;
    localparam int QUIET_MAX  = 3000;
    localparam int MAX_REPORT = 10;

    localparam logic [htlf_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [htlf_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [htlf_pkg::STATUS_W-1:0] st;
        logic [htlf_pkg::SLOT_W-1:0]   slot;
        logic [htlf_pkg::RES_IN_W-1:0] res;
        logic [htlf_pkg::OFFSET_W-1:0] off;
        logic [htlf_pkg::USED_W-1:0]   used;
    } table_reply_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic [htlf_pkg::OPCODE_W-1:0] opcode       = '0;
    logic [htlf_pkg::HANDLE_W-1:0] handle_index = '0;
    logic [htlf_pkg::RES_IN_W-1:0] resource_id  = '0;
    logic [htlf_pkg::OFFSET_W-1:0] start_offset = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic [htlf_pkg::STATUS_W-1:0] status;
    logic [htlf_pkg::SLOT_W-1:0]   slot_index;
    logic [htlf_pkg::RES_IN_W-1:0] found_resource;
    logic [htlf_pkg::OFFSET_W-1:0] found_offset;
    logic [htlf_pkg::USED_W-1:0]   used_count;

    // predicted table contents
    bit                            held [DEPTH];
    logic [htlf_pkg::RES_IN_W-1:0] res_store [DEPTH];
    logic [htlf_pkg::OFFSET_W-1:0] off_store [DEPTH];
    int                            span_count = 0;

    table_reply_t pending_replies [$];

    bit sender_idles    = 1'b1;
    bit receiver_stalls = 1'b1;

    int requests_sent   = 0;
    int replies_checked = 0;
    int mismatches      = 0;
    int full_allocs     = 0;
    int peak_used       = 0;
    int quiet_cycles    = 0;
    int status_seen [4];

    handle_table_lowest_free_top #(
        .TABLE_DEPTH      (DEPTH),
        .RESOURCE_ID_BITS (htlf_pkg::RES_IN_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .handle_index   (handle_index),
        .resource_id    (resource_id),
        .start_offset   (start_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_index     (slot_index),
        .found_resource (found_resource),
        .found_offset   (found_offset),
        .used_count     (used_count)
    );

    always #5 clk = ~clk;

    function automatic void occupy_slot(input int i,
                                        input logic [htlf_pkg::RES_IN_W-1:0] res,
                                        input logic [htlf_pkg::OFFSET_W-1:0] off);
        held[i]      = 1'b1;
        res_store[i] = res;
        off_store[i] = off;
        if (i + 1 > span_count)
            span_count = i + 1;
    endfunction

    function automatic table_reply_t table_apply(input logic [htlf_pkg::OPCODE_W-1:0] op,
                                                 input logic [htlf_pkg::HANDLE_W-1:0] idx,
                                                 input logic [htlf_pkg::RES_IN_W-1:0] res,
                                                 input logic [htlf_pkg::OFFSET_W-1:0] off);
        table_reply_t r;
        bit found;
        int i;
        r = '0;
        r.st   = htlf_pkg::ST_OK;
        r.slot = idx[htlf_pkg::SLOT_W-1:0];
        found  = 1'b0;
        case (op)
            htlf_pkg::OP_ALLOC:
            begin
                r.slot = '0;
                r.st   = htlf_pkg::ST_FULL;
                for (i = 0; i < DEPTH && !found; i++)
                begin
                    if (!held[i])
                    begin
                        occupy_slot(i, res, '0);
                        r.st   = htlf_pkg::ST_OK;
                        r.slot = htlf_pkg::SLOT_W'(i);
                        found  = 1'b1;
                    end
                end
                if (!found)
                    full_allocs++;
            end
            htlf_pkg::OP_INHERIT:
            begin
                if (idx >= DEPTH)
                    r.st = htlf_pkg::ST_FULL;
                else if (held[idx])
                    r.st = htlf_pkg::ST_BUSY;
                else
                    occupy_slot(idx, res, off);
            end
            htlf_pkg::OP_GET:
            begin
                if (idx >= DEPTH || !held[idx])
                    r.st = htlf_pkg::ST_BAD;
                else
                begin
                    r.res = res_store[idx];
                    r.off = off_store[idx];
                end
            end
            htlf_pkg::OP_CLOSE:
            begin
                if (idx >= DEPTH || !held[idx])
                    r.st = htlf_pkg::ST_BAD;
                else
                begin
                    held[idx]      = 1'b0;
                    off_store[idx] = '0;
                    while (span_count > 0 && !held[span_count - 1])
                        span_count--;
                end
            end
            htlf_pkg::OP_CLEAR:
            begin
                for (i = 0; i < DEPTH; i++)
                    held[i] = 1'b0;
                span_count = 0;
                r.slot     = '0;
            end
            default:
            begin
                r.st   = htlf_pkg::ST_BAD;
                r.slot = '0;
            end
        endcase
        r.used = htlf_pkg::USED_W'(span_count);
        return r;
    endfunction

    function automatic logic [htlf_pkg::RES_IN_W-1:0] rand_resource();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return htlf_pkg::RES_IN_W'($urandom);
    endfunction

    function automatic logic [htlf_pkg::OFFSET_W-1:0] rand_offset();
        logic [63:0] w;
        int pick;
        w    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return w[htlf_pkg::OFFSET_W-1:0];
    endfunction

    // occupied_pct: chance of addressing a slot that currently holds a resource
    function automatic logic [htlf_pkg::HANDLE_W-1:0] pick_handle(input int occupied_pct);
        int occ [$];
        int i;
        for (i = 0; i < DEPTH; i++)
            if (held[i])
                occ.push_back(i);
        if (occ.size() != 0 && $urandom_range(99) < occupied_pct)
            return htlf_pkg::HANDLE_W'(occ[$urandom_range(occ.size() - 1)]);
        if ($urandom_range(99) < 15)
            return htlf_pkg::HANDLE_W'($urandom_range(255, DEPTH));
        return htlf_pkg::HANDLE_W'($urandom_range(DEPTH - 1));
    endfunction

    task automatic send_request(input logic [htlf_pkg::OPCODE_W-1:0] op,
                                input logic [htlf_pkg::HANDLE_W-1:0] idx,
                                input logic [htlf_pkg::RES_IN_W-1:0] res,
                                input logic [htlf_pkg::OFFSET_W-1:0] off);
        table_reply_t r;
        if (sender_idles)
        begin
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        handle_index <= idx;
        resource_id  <= res;
        start_offset <= off;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = table_apply(op, idx, res, off);
        pending_replies.push_back(r);
        requests_sent++;
        status_seen[r.st]++;
        if (span_count > peak_used)
            peak_used = span_count;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [htlf_pkg::OPCODE_W-1:0] op;
        send_request(htlf_pkg::OP_GET,     8'd0,   16'h0000, 48'h0);
        send_request(htlf_pkg::OP_CLOSE,   8'd0,   16'h0000, 48'h0);
        send_request(htlf_pkg::OP_GET,     8'd255, 16'h0000, 48'h0);
        send_request(htlf_pkg::OP_CLOSE,   8'd127, 16'h0000, 48'h0);
        send_request(htlf_pkg::OP_INHERIT, 8'd64,  16'h5555, 48'h1);
        send_request(htlf_pkg::OP_INHERIT, 8'd255, 16'hAAAA, 48'h2);
        send_request(htlf_pkg::OP_ALLOC,   8'd0,   16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(htlf_pkg::OP_INHERIT, 8'd63,  16'hABCD, 48'hFFFF_FFFF_FFFF);
        send_request(htlf_pkg::OP_INHERIT, 8'd63,  16'h1111, 48'h3);
        send_request(htlf_pkg::OP_GET,     8'd63,  16'h0000, 48'h0);
        send_request(htlf_pkg::OP_GET,     8'd0,   16'h0000, 48'h0);
        send_request(htlf_pkg::OP_CLOSE,   8'd63,  16'h0000, 48'h0);
        send_request(htlf_pkg::OP_INHERIT, 8'd20,  16'h0000, 48'h0000_0000_0001);
        send_request(htlf_pkg::OP_INHERIT, 8'd10,  16'h1234, 48'h8000_0000_0000);
        send_request(htlf_pkg::OP_CLOSE,   8'd20,  16'h0000, 48'h0);
        send_request(htlf_pkg::OP_ALLOC,   8'd200, 16'h0000, 48'h7777_7777_7777);
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++)
            send_request(op, 8'd45, 16'h4321, 48'h1);
        send_request(htlf_pkg::OP_CLEAR,   8'd33,  16'h0000, 48'h0);
        send_request(htlf_pkg::OP_GET,     8'd10,  16'h0000, 48'h0);
        send_request(htlf_pkg::OP_ALLOC,   8'd0,   16'h00FF, 48'h0);
        send_request(htlf_pkg::OP_CLOSE,   8'd0,   16'h0000, 48'h0);
        hold_until_drained();
    endtask

    task automatic test_random_mix(input int count);
        int n;
        int pick;
        logic [htlf_pkg::OPCODE_W-1:0] op;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                op = htlf_pkg::OP_ALLOC;
            else if (pick < 50)
                op = htlf_pkg::OP_INHERIT;
            else if (pick < 70)
                op = htlf_pkg::OP_GET;
            else if (pick < 95)
                op = htlf_pkg::OP_CLOSE;
            else if (pick < 96)
                op = htlf_pkg::OP_CLEAR;
            else
                op = htlf_pkg::OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            send_request(op, pick_handle(op == htlf_pkg::OP_INHERIT ? 30 : 70),
                         rand_resource(), rand_offset());
            if ($urandom_range(99) < 2)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    // fill the table to full, then empty it top-down, in random order, bottom-up
    task automatic test_fill_and_empty();
        int round_no;
        int k;
        logic [htlf_pkg::HANDLE_W-1:0] idx;
        for (round_no = 0; round_no < 3; round_no++)
        begin
            send_request(htlf_pkg::OP_CLEAR, pick_handle(0), rand_resource(), rand_offset());
            send_request(htlf_pkg::OP_INHERIT, htlf_pkg::HANDLE_W'(DEPTH - 1),
                         rand_resource(), rand_offset());
            repeat (DEPTH + 1)
                send_request(htlf_pkg::OP_ALLOC, pick_handle(50), rand_resource(),
                             rand_offset());
            repeat (12)
                send_request($urandom_range(1) ? htlf_pkg::OP_GET : htlf_pkg::OP_INHERIT,
                             pick_handle(90), rand_resource(), rand_offset());
            for (k = 0; k < DEPTH; k++)
            begin
                if (round_no == 0)
                    idx = htlf_pkg::HANDLE_W'(DEPTH - 1 - k);
                else if (round_no == 1)
                    idx = pick_handle(100);
                else
                    idx = htlf_pkg::HANDLE_W'(k);
                send_request(htlf_pkg::OP_CLOSE, idx, rand_resource(), rand_offset());
            end
            hold_until_drained();
        end
    endtask

    task automatic test_back_to_back();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        test_random_mix(300);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    always @(posedge clk)
    begin : check_replies
        table_reply_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("unexpected reply: status %0d slot %0d used %0d",
                                 status, slot_index, used_count);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (status !== want.st || slot_index !== want.slot ||
                        found_resource !== want.res || found_offset !== want.off ||
                        used_count !== want.used)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display({"reply %0d mismatch: exp st %0d slot %0d res %h off %h ",
                                      "used %0d, got st %0d slot %0d res %h off %h used %0d"},
                                     replies_checked, want.st, want.slot, want.res, want.off,
                                     want.used, status, slot_index, found_resource,
                                     found_offset, used_count);
                    end
                end
            end
            out_ready <= !(receiver_stalls && $urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(560);
        test_fill_and_empty();
        test_back_to_back();
        hold_until_drained();
        repeat (20)
            @(posedge clk);
        $display("covered %0d requests, %0d replies checked, %0d mismatches",
                 requests_sent, replies_checked, mismatches);
        $display("status ok/bad/full/busy %0d/%0d/%0d/%0d, alloc on full %0d, peak used %0d",
                 status_seen[htlf_pkg::ST_OK], status_seen[htlf_pkg::ST_BAD],
                 status_seen[htlf_pkg::ST_FULL], status_seen[htlf_pkg::ST_BUSY],
                 full_allocs, peak_used);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
